### hdl/assert_macros.svh
// Assertion helpers shared by the jitter sequencer modules.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AJS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that, once seen, must be followed by another on the next edge.
`define AJS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ajs_pkg.sv
package ajs_pkg;

  localparam int HANDLE_BITS   = 16;
  localparam int SEQ_BITS      = 8;
  localparam int LEVEL_BITS    = 11;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPECTED_FORMAT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_FRAMES    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_QUEUED      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GAP_FILL    = 2'd3;

  localparam logic [7:0] RST_EXPECTED_FORMAT = 8'd0;
  localparam logic [9:0] RST_PRIME_FRAMES    = 10'd24;
  localparam logic [9:0] RST_MAX_QUEUED      = 10'd80;
  localparam logic [5:0] RST_MAX_GAP_FILL    = 6'd8;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_DRAIN = 2'd1,
    ACT_RESET = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_SILENCE = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_START   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [SEQ_BITS-1:0]    packet_seq;
    logic [7:0]             frames_in_packet;
    logic [7:0]             frame_index;
    logic [7:0]             format;
    logic [HANDLE_BITS-1:0] frame_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   start_playback;
    logic                   last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_DATA,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic drain;
    logic clear;
    logic setup;
    logic step_silence;
    logic step_data;
    logic emit_start;
  } cmd_t;

  typedef struct packed {
    logic is_drain;
    logic is_reset;
    logic frame_ok;
    logic out_free;
    logic gap_left;
    logic data_pending;
    logic need_start;
  } status_t;

endpackage

### hdl/ajs_ctrl.sv
`include "assert_macros.svh"

module ajs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ajs_pkg::status_t status,
  output ajs_pkg::cmd_t    cmd
);

  ajs_pkg::state_t state_r;
  ajs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ajs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ajs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ajs_pkg::S_DECODE;
        end
      end
      ajs_pkg::S_DECODE: begin
        if (status.is_drain) begin
          cmd.drain = 1'b1;
          state_nxt = ajs_pkg::S_IDLE;
        end else if (status.is_reset) begin
          if (status.out_free) begin
            cmd.clear = 1'b1;
            state_nxt = ajs_pkg::S_IDLE;
          end
        end else if (status.frame_ok) begin
          cmd.setup = 1'b1;
          state_nxt = ajs_pkg::S_FILL;
        end else begin
          state_nxt = ajs_pkg::S_IDLE;
        end
      end
      ajs_pkg::S_FILL: begin
        // One silence attempt per cycle while the output register is free, until the gap counter runs out.
        if (status.gap_left) begin
          if (status.out_free) begin
            cmd.step_silence = 1'b1;
          end
        end else begin
          state_nxt = ajs_pkg::S_DATA;
        end
      end
      ajs_pkg::S_DATA: begin
        if (status.data_pending) begin
          if (status.out_free) begin
            cmd.step_data = 1'b1;
            state_nxt     = ajs_pkg::S_FINISH;
          end
        end else begin
          state_nxt = ajs_pkg::S_FINISH;
        end
      end
      ajs_pkg::S_FINISH: begin
        // A start with nothing queued for this request needs a result of its own.
        if (status.need_start) begin
          if (status.out_free) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ajs_pkg::S_IDLE;
          end
        end else begin
          state_nxt = ajs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ajs_pkg::S_IDLE;
      end
    endcase
  end

  `AJS_ASSERT(a_idle_no_work, state_r == ajs_pkg::S_IDLE |-> !status.gap_left && !status.data_pending, "idle with frame work left")

endmodule

### hdl/ajs_datapath.sv
`include "assert_macros.svh"

module ajs_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ajs_pkg::in_item_t                    in_data,
  input  logic                                 cfg_valid,
  input  logic [ajs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ajs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ajs_pkg::out_item_t                   out_data,
  input  ajs_pkg::cmd_t                        cmd,
  output ajs_pkg::status_t                     status
);

  logic [7:0] exp_format_r;
  logic [9:0] prime_r;
  logic [9:0] max_queued_r;
  logic [5:0] max_gap_r;

  ajs_pkg::in_item_t item_r, item_nxt;
  logic                              have_last_r, have_last_nxt;
  logic [ajs_pkg::SEQ_BITS-1:0]      last_seq_r, last_seq_nxt;
  logic                              primed_r, primed_nxt;
  logic [ajs_pkg::LEVEL_BITS-1:0]    level_r, level_nxt;
  logic [5:0]                        cnt_r, cnt_nxt;
  logic                              data_pend_r, data_pend_nxt;
  logic                              emitted_r, emitted_nxt;
  logic                              out_valid_r, out_valid_nxt;
  ajs_pkg::out_item_t                out_data_r, out_data_nxt;

  logic [ajs_pkg::SEQ_BITS-1:0]   fseq;
  logic [ajs_pkg::SEQ_BITS-1:0]   seq_dist;
  logic [6:0]                     missing;
  logic                           accept;
  logic                           fill;
  logic                           is_end;
  logic                           step;
  logic                           can_q;
  logic [ajs_pkg::LEVEL_BITS-1:0] level_inc;
  logic [ajs_pkg::LEVEL_BITS-1:0] max_ext;
  logic [ajs_pkg::LEVEL_BITS-1:0] prime_ext;
  logic                           more_after;
  logic                           last_emit;
  logic                           start_here;
  logic                           emit_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_format_r <= ajs_pkg::RST_EXPECTED_FORMAT;
      prime_r      <= ajs_pkg::RST_PRIME_FRAMES;
      max_queued_r <= ajs_pkg::RST_MAX_QUEUED;
      max_gap_r    <= ajs_pkg::RST_MAX_GAP_FILL;
    end else if (cfg_valid) begin
      case (cfg_index)
        ajs_pkg::CFG_EXPECTED_FORMAT: exp_format_r <= cfg_data[7:0];
        ajs_pkg::CFG_PRIME_FRAMES:    prime_r      <= cfg_data[9:0];
        ajs_pkg::CFG_MAX_QUEUED:      max_queued_r <= cfg_data[9:0];
        ajs_pkg::CFG_MAX_GAP_FILL:    max_gap_r    <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Frame sequence and its wrap-safe distance to the last accepted frame.
  assign fseq     = item_r.packet_seq - item_r.frames_in_packet + 8'd1 + item_r.frame_index;
  assign seq_dist = fseq - last_seq_r;
  assign missing  = seq_dist[6:0] - 7'd1;
  assign accept   = !have_last_r || ((seq_dist != 8'd0) && !seq_dist[7]);
  assign fill     = have_last_r && accept && (missing != 7'd0) &&
                    (missing <= {1'b0, max_gap_r});
  assign is_end   = (item_r.frame_index == (item_r.frames_in_packet - 8'd1));

  assign max_ext    = {1'b0, max_queued_r};
  assign prime_ext  = {1'b0, prime_r};
  assign level_inc  = level_r + 11'd1;
  assign step       = cmd.step_silence | cmd.step_data;
  assign can_q      = (level_r <= max_ext);
  // Nothing after this result can be queued if no attempt remains or the cap is hit.
  assign more_after = cmd.step_silence && ((cnt_r != 6'd1) || data_pend_r);
  assign last_emit  = !more_after || (level_inc > max_ext);
  assign start_here = last_emit && is_end && !primed_r && (level_inc >= prime_ext);
  assign emit_now   = cmd.clear | cmd.emit_start | (step & can_q);

  always_comb begin
    item_nxt      = item_r;
    have_last_nxt = have_last_r;
    last_seq_nxt  = last_seq_r;
    primed_nxt    = primed_r;
    level_nxt     = level_r;
    cnt_nxt       = cnt_r;
    data_pend_nxt = data_pend_r;
    emitted_nxt   = emitted_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (cmd.load) begin
      item_nxt = in_data;
    end
    if (cmd.drain && (level_r != '0)) begin
      level_nxt = level_r - 11'd1;
    end
    if (cmd.clear) begin
      have_last_nxt = 1'b0;
      last_seq_nxt  = '0;
      primed_nxt    = 1'b0;
      level_nxt     = '0;
    end
    if (cmd.setup) begin
      cnt_nxt       = fill ? missing[5:0] : 6'd0;
      data_pend_nxt = accept;
      emitted_nxt   = 1'b0;
    end
    if (step && can_q) begin
      level_nxt   = level_inc;
      emitted_nxt = 1'b1;
      if (start_here) begin
        primed_nxt = 1'b1;
      end
    end
    if (cmd.step_silence) begin
      cnt_nxt = cnt_r - 6'd1;
    end
    if (cmd.step_data) begin
      data_pend_nxt = 1'b0;
      last_seq_nxt  = fseq;
      have_last_nxt = 1'b1;
    end
    if (cmd.emit_start) begin
      primed_nxt = 1'b1;
    end

    if (emit_now) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.clear) begin
      out_data_nxt.kind           = ajs_pkg::KIND_CLEAR;
      out_data_nxt.out_handle     = '0;
      out_data_nxt.start_playback = 1'b0;
      out_data_nxt.last           = 1'b1;
    end else if (cmd.emit_start) begin
      out_data_nxt.kind           = ajs_pkg::KIND_START;
      out_data_nxt.out_handle     = '0;
      out_data_nxt.start_playback = 1'b1;
      out_data_nxt.last           = 1'b1;
    end else if (step && can_q) begin
      out_data_nxt.kind           = cmd.step_silence ? ajs_pkg::KIND_SILENCE : ajs_pkg::KIND_DATA;
      out_data_nxt.out_handle     = cmd.step_silence ? '0 : item_r.frame_handle;
      out_data_nxt.start_playback = start_here;
      out_data_nxt.last           = last_emit;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      last_seq_r  <= '0;
      primed_r    <= 1'b0;
      level_r     <= '0;
      cnt_r       <= '0;
      data_pend_r <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_last_r <= have_last_nxt;
      last_seq_r  <= last_seq_nxt;
      primed_r    <= primed_nxt;
      level_r     <= level_nxt;
      cnt_r       <= cnt_nxt;
      data_pend_r <= data_pend_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    status              = '0;
    status.is_drain     = (item_r.action == ajs_pkg::ACT_DRAIN);
    status.is_reset     = (item_r.action == ajs_pkg::ACT_RESET);
    status.frame_ok     = (item_r.action == ajs_pkg::ACT_FRAME) &&
                          (item_r.format == exp_format_r) &&
                          (item_r.frames_in_packet != 8'd0) &&
                          (item_r.frame_index < item_r.frames_in_packet);
    status.out_free     = !out_valid_r || out_ready;
    status.gap_left     = (cnt_r != 6'd0);
    status.data_pending = data_pend_r;
    status.need_start   = is_end && !primed_r && !emitted_r && (level_r >= prime_ext);
  end

  `AJS_ASSERT(a_level_bound, level_r <= 11'd1024, "queue level beyond cap plus one")
  `AJS_ASSERT(a_start_is_last, out_valid_r && out_data_r.start_playback |-> out_data_r.last, "start flag on a result that is not last")
  `AJS_ASSERT_NEXT(a_clear_state, cmd.clear, level_r == '0 && !have_last_r && !primed_r, "reset request left tracking state")

endmodule

### hdl/audio_jitter_sequencer.sv
// One request at a time: a checked frame passes decode, fill, data and finish, with one
// silence result per missing frame of a filled gap (up to 63), and a frame with no gap
// has its result registered from data; a drain, reset or ignored request ends in decode.
// Each result step also waits while the output register is full and not taken.
// Reset (rst_n low, synchronous) restores the register defaults, clears tracking state
// and pauses playback; no clearing pass is needed.
module audio_jitter_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ajs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ajs_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ajs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ajs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  ajs_pkg::cmd_t    cmd;
  ajs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  ajs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ajs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### sim/audio_jitter_sequencer_tb.sv
`timescale 1ns / 1ps

module audio_jitter_sequencer_tb;
  import ajs_pkg::*;

  localparam int RUN_LIMIT     = 3_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  audio_jitter_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Register mirrors, updated when a write is taken.
  logic [7:0] exp_format  = RST_EXPECTED_FORMAT;
  logic [9:0] prime_level = RST_PRIME_FRAMES;
  logic [9:0] queue_cap   = RST_MAX_QUEUED;
  logic [5:0] gap_limit   = RST_MAX_GAP_FILL;

  // Jitter buffer tracking state.
  logic        seq_valid    = 1'b0;
  logic [7:0]  seq_last     = 8'd0;
  logic        play_started = 1'b0;
  logic [10:0] frame_level  = 11'd0;

  in_item_t  request_queue[$];
  out_item_t expected_events[$];
  out_item_t step_results[$];

  int fail_count = 0;
  int cycle_count = 0;

  // Stimulus generation state.
  logic [7:0] gen_seq = 8'd0;
  logic [7:0] phase_fmt = RST_EXPECTED_FORMAT;
  int         phase_gap = RST_MAX_GAP_FILL;
  bit         hold_request = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic offer_frame(input logic [1:0] kind, input logic [15:0] handle);
    out_item_t ev;
    if (frame_level <= {1'b0, queue_cap}) begin
      frame_level = frame_level + 11'd1;
      ev.kind = kind;
      ev.out_handle = handle;
      ev.start_playback = 1'b0;
      ev.last = 1'b0;
      step_results.push_back(ev);
    end
  endtask

  task automatic track_request(input in_item_t req);
    out_item_t  ev;
    logic       start;
    logic [7:0] fseq;
    logic [7:0] seq_dist;
    int         missing;
    start = 1'b0;
    step_results.delete();
    case (req.action)
      ACT_DRAIN: begin
        if (frame_level != 11'd0) frame_level = frame_level - 11'd1;
      end
      ACT_RESET: begin
        seq_valid = 1'b0;
        seq_last = 8'd0;
        play_started = 1'b0;
        frame_level = 11'd0;
        ev.kind = KIND_CLEAR;
        ev.out_handle = '0;
        ev.start_playback = 1'b0;
        ev.last = 1'b1;
        step_results.push_back(ev);
      end
      ACT_FRAME: begin
        if (req.format == exp_format && req.frames_in_packet != 8'd0 &&
            req.frame_index < req.frames_in_packet) begin
          fseq = req.packet_seq - (req.frames_in_packet - 8'd1) + req.frame_index;
          if (!seq_valid) begin
            offer_frame(KIND_DATA, req.frame_handle);
            seq_last = fseq;
            seq_valid = 1'b1;
          end else begin
            seq_dist = fseq - seq_last;
            // Distances of zero or of 128 and up are repeated or late frames.
            if (seq_dist != 8'd0 && seq_dist < 8'd128) begin
              missing = int'(seq_dist) - 1;
              if (missing > 0 && missing <= int'(gap_limit)) begin
                for (int k = 0; k < missing; k++) offer_frame(KIND_SILENCE, 16'h0000);
              end
              offer_frame(KIND_DATA, req.frame_handle);
              seq_last = fseq;
            end
          end
          if (req.frame_index == req.frames_in_packet - 8'd1 && !play_started &&
              frame_level >= {1'b0, prime_level}) begin
            play_started = 1'b1;
            start = 1'b1;
          end
          if (start && step_results.size() == 0) begin
            ev.kind = KIND_START;
            ev.out_handle = '0;
            ev.start_playback = 1'b0;
            ev.last = 1'b0;
            step_results.push_back(ev);
          end
          if (step_results.size() > 0) begin
            step_results[step_results.size()-1].start_playback = start;
            step_results[step_results.size()-1].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
    foreach (step_results[i]) expected_events.push_back(step_results[i]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected result: kind %0d handle %h", got.kind, got.out_handle);
      fail_count++;
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.out_handle !== want.out_handle) begin
        $error("out_handle: expected %h, got %h", want.out_handle, got.out_handle);
        fail_count++;
      end
      if (got.start_playback !== want.start_playback) begin
        $error("start_playback: expected %0d, got %0d", want.start_playback,
               got.start_playback);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count++;
      end
    end
  endtask

  // Request driver.
  int feed_idle = 0;
  int feed_steady = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_request(in_data);
      if (in_valid && !in_ready) begin
        // Hold the current request until it is taken.
      end else if (feed_idle > 0) begin
        feed_idle--;
        in_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= request_queue.pop_front();
        if (feed_steady > 0) feed_steady--;
        else if ($urandom_range(0, 24) == 0) feed_steady = $urandom_range(20, 50);
        else feed_idle = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure.
  int sink_stall = 0;
  int sink_steady = 0;
  int sink_hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        sink_hold = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (sink_steady > 0) sink_steady--;
        else if ($urandom_range(0, 29) == 0) sink_steady = $urandom_range(30, 80);
        else if ($urandom_range(0, 2) == 0) sink_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EXPECTED_FORMAT: exp_format = val[7:0];
      CFG_PRIME_FRAMES:    prime_level = val;
      CFG_MAX_QUEUED:      queue_cap = val;
      CFG_MAX_GAP_FILL:    gap_limit = val[5:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] fmt, input int prime, input int cap,
                           input int gap);
    write_reg(CFG_EXPECTED_FORMAT, {2'b00, fmt});
    write_reg(CFG_PRIME_FRAMES, 10'(prime));
    write_reg(CFG_MAX_QUEUED, 10'(cap));
    write_reg(CFG_MAX_GAP_FILL, 10'(gap));
    phase_fmt = fmt;
    phase_gap = gap;
  endtask

  task automatic push_frame(input logic [7:0] seq, input logic [7:0] n,
                            input logic [7:0] idx, input logic [7:0] fmt,
                            input logic [15:0] handle);
    in_item_t req;
    req.action = ACT_FRAME;
    req.packet_seq = seq;
    req.frames_in_packet = n;
    req.frame_index = idx;
    req.format = fmt;
    req.frame_handle = handle;
    request_queue.push_back(req);
  endtask

  // Non-frame requests carry random payload that the block must ignore.
  task automatic push_op(input logic [1:0] action);
    in_item_t req;
    req.action = action;
    req.packet_seq = 8'($urandom);
    req.frames_in_packet = 8'($urandom);
    req.frame_index = 8'($urandom);
    req.format = 8'($urandom);
    req.frame_handle = 16'($urandom);
    request_queue.push_back(req);
  endtask

  task automatic random_traffic(input int count);
    int         made;
    int         r;
    int         n;
    int         k;
    int         skip;
    logic [7:0] first;
    logic [7:0] pseq;
    logic [7:0] fmt;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 99);
        if (r < 70) skip = 0;
        else if (r < 90) skip = $urandom_range(1, phase_gap + 2);
        else skip = $urandom_range(120, 255);
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(1, 3);
        else if (r < 95) n = $urandom_range(4, 8);
        else n = $urandom_range(100, 255);
        // Of a long packet only the newest frames are sent.
        k = (n > 8) ? $urandom_range(1, 2) : n;
        fmt = ($urandom_range(0, 19) == 0) ? 8'($urandom) : phase_fmt;
        first = gen_seq + 8'(skip);
        pseq = first + 8'(n - 1);
        for (int idx = n - k; idx < n; idx++) begin
          push_frame(pseq, 8'(n), 8'(idx), fmt, 16'($urandom));
          made++;
        end
        gen_seq = pseq + 8'd1;
      end else if (r < 85) begin
        k = $urandom_range(1, 3);
        repeat (k) push_op(ACT_DRAIN);
        made += k;
      end else if (r < 88) begin
        push_op(ACT_RESET);
        made++;
      end else begin
        push_op(2'($urandom));
        request_queue[request_queue.size()-1].action = 2'($urandom);
        made++;
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults: gap handling, drops and the ignored cases.
    push_frame(8'd10, 8'd1, 8'd0, 8'h00, 16'hFFFF);
    push_frame(8'd10, 8'd1, 8'd0, 8'h00, 16'h1234);
    push_frame(8'd13, 8'd1, 8'd0, 8'h00, 16'h0001);
    push_frame(8'd200, 8'd1, 8'd0, 8'h00, 16'h0002);
    push_frame(8'd33, 8'd1, 8'd0, 8'h00, 16'h0003);
    push_frame(8'd34, 8'd1, 8'd0, 8'hFF, 16'h0004);
    push_frame(8'd34, 8'd0, 8'd0, 8'h00, 16'h0005);
    push_frame(8'd34, 8'd3, 8'd3, 8'h00, 16'h0006);
    push_frame(8'd34, 8'hFF, 8'hFE, 8'h00, 16'h8000);
    push_op(ACT_DRAIN);
    push_op(2'd3);
    push_op(ACT_RESET);
    push_op(ACT_DRAIN);
    push_frame(8'd0, 8'd2, 8'd0, 8'h00, 16'h0000);
    push_frame(8'd0, 8'd2, 8'd1, 8'h00, 16'hAAAA);
    push_frame(8'd9, 8'd1, 8'd0, 8'h00, 16'h5555);
    settle();

    // Start on a dropped frame, then a fill cut short by a full queue.
    configure(8'hA5, 1, 2, 63);
    @(negedge clk);
    push_op(ACT_RESET);
    push_frame(8'd50, 8'd2, 8'd0, 8'hA5, 16'h0F0F);
    push_frame(8'd49, 8'd1, 8'd0, 8'hA5, 16'hF0F0);
    push_frame(8'd113, 8'd1, 8'd0, 8'hA5, 16'h1111);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(8'hFF, 0, 1023, 63);
        1: configure(8'h00, 1023, 0, 0);
        2: configure(8'($urandom), 4, 12, 5);
        5: configure(8'($urandom), $urandom_range(0, 40), 1023, 63);
        default: configure(8'($urandom), $urandom_range(0, 40), $urandom_range(10, 100),
                           $urandom_range(0, 63));
      endcase
      @(negedge clk);
      if (ph == 0) begin
        // Longest fill: a full gap of silence ahead of one data frame.
        push_op(ACT_RESET);
        push_frame(8'd0, 8'd1, 8'd0, 8'hFF, 16'h2222);
        push_frame(8'd64, 8'd1, 8'd0, 8'hFF, 16'h3333);
        gen_seq = 8'd65;
      end
      // The last phase stalls the receiver so the block backs up.
      if (ph == 5) hold_request = 1'b1;
      random_traffic(40);
      settle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
